// ----- sv/ifsf_pkg.sv -----
package ifsf_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 3;

	// job queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FLAG      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLAG_SUB  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ESC_SUB   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CTRL_SEQ1 = 3'd6;

	// register reset values
	localparam logic [BYTE_W-1:0] RST_FLAG      = 8'd126;
	localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'd3;
	localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd125;
	localparam logic [BYTE_W-1:0] RST_FLAG_SUB  = 8'd94;
	localparam logic [BYTE_W-1:0] RST_ESC_SUB   = 8'd93;
	localparam logic [BYTE_W-1:0] RST_CTRL_SEQ0 = 8'd0;
	localparam logic [BYTE_W-1:0] RST_CTRL_SEQ1 = 8'd64;

	typedef struct packed {
		logic [BYTE_W-1:0] flag_code;
		logic [BYTE_W-1:0] address_code;
		logic [BYTE_W-1:0] escape_code;
		logic [BYTE_W-1:0] flag_substitute;
		logic [BYTE_W-1:0] escape_substitute;
		logic [BYTE_W-1:0] control_seq_zero;
		logic [BYTE_W-1:0] control_seq_one;
	} cfg_t;

	// one classified payload item, as handed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] payload;
		logic [BYTE_W-1:0] check;    // running XOR including this byte
		logic              first;    // opens a frame: header goes out first
		logic              last;     // closes the frame: check and flag follow
		logic              seq;
	} job_t;

endpackage

// ----- sv/info_frame_stuffing_framer.sv -----
// An accepted payload beat passes through the job queue and the output register.
// The back sequencer gives one line beat per cycle while the line side is ready;
//   a payload beat makes 1 to 9 line beats (header, escapes, check, closing flag).
// The two-entry job queue lets the front accept while the back still expands.
// Reset (arst_n low, asynchronous): registers take their defaults, the frame
//   state and check clear, the queue and output register empty.
module info_frame_stuffing_framer
	import ifsf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	// payload stream in
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,    // [7:0] payload_byte
	input  logic                 s_tlast,    // last_byte
	input  logic                 s_tuser,    // seq_bit
	// line stream out
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,    // [7:0] line_byte
	output logic                 m_tlast,    // run_last
	output logic                 m_tuser     // frame_end
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	// Register bank: writes land directly, unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_code         <= RST_FLAG;
			cfg_q.address_code      <= RST_ADDRESS;
			cfg_q.escape_code       <= RST_ESCAPE;
			cfg_q.flag_substitute   <= RST_FLAG_SUB;
			cfg_q.escape_substitute <= RST_ESC_SUB;
			cfg_q.control_seq_zero  <= RST_CTRL_SEQ0;
			cfg_q.control_seq_one   <= RST_CTRL_SEQ1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FLAG:      cfg_q.flag_code         <= cfg_data;
				REG_ADDRESS:   cfg_q.address_code      <= cfg_data;
				REG_ESCAPE:    cfg_q.escape_code       <= cfg_data;
				REG_FLAG_SUB:  cfg_q.flag_substitute   <= cfg_data;
				REG_ESC_SUB:   cfg_q.escape_substitute <= cfg_data;
				REG_CTRL_SEQ0: cfg_q.control_seq_zero  <= cfg_data;
				REG_CTRL_SEQ1: cfg_q.control_seq_one   <= cfg_data;
				default:       cfg_q                   <= cfg_q;
			endcase
		end
	end

	// Front: track frame position and running check, classify each beat.
	ifsf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.q_full       (q_full),
		.payload_byte (s_tdata),
		.last_byte    (s_tlast),
		.seq_bit      (s_tuser),
		.in_ready     (s_tready),
		.push         (push),
		.push_job     (push_job)
	);

	// Queue: decouple classification from expansion.
	ifsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back: expand each job into header, stuffed bytes, check and closing flag.
	ifsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.line_byte  (m_tdata),
		.run_last   (m_tlast),
		.frame_end  (m_tuser)
	);

endmodule

// ----- sv/ifsf_front.sv -----
module ifsf_front
	import ifsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              q_full,
	input  logic [BYTE_W-1:0] payload_byte,
	input  logic              last_byte,
	input  logic              seq_bit,
	output logic              in_ready,
	output logic              push,
	output job_t              push_job
);

	logic              in_frame_q;
	logic [BYTE_W-1:0] acc_q;
	logic [BYTE_W-1:0] acc_next;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// restart the check on the first byte of a frame
	assign acc_next = (in_frame_q ? acc_q : '0) ^ payload_byte;

	always_comb begin
		push_job.payload = payload_byte;
		push_job.check   = acc_next;
		push_job.first   = !in_frame_q;
		push_job.last    = last_byte;
		push_job.seq     = seq_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			acc_q      <= '0;
		end else if (push) begin
			in_frame_q <= !last_byte;
			acc_q      <= last_byte ? '0 : acc_next;
		end
	end

endmodule

// ----- sv/ifsf_queue.sv -----
module ifsf_queue
	import ifsf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ----- sv/ifsf_back.sv -----
module ifsf_back
	import ifsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              head_valid,
	input  job_t              head_job,
	output logic              pop,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [BYTE_W-1:0] line_byte,
	output logic              run_last,
	output logic              frame_end
);

	localparam logic [3:0] PH_START    = 4'd0;
	localparam logic [3:0] PH_HDR_FLAG = 4'd1;
	localparam logic [3:0] PH_HDR_ADDR = 4'd2;
	localparam logic [3:0] PH_HDR_CTRL = 4'd3;
	localparam logic [3:0] PH_HDR_CHK  = 4'd4;
	localparam logic [3:0] PH_PAY      = 4'd5;
	localparam logic [3:0] PH_PAY_SUB  = 4'd6;
	localparam logic [3:0] PH_CHK      = 4'd7;
	localparam logic [3:0] PH_CHK_SUB  = 4'd8;
	localparam logic [3:0] PH_CLOSE    = 4'd9;

	logic [3:0]        phase_q;
	logic [3:0]        phase_cur;
	logic [3:0]        phase_nxt;
	logic              load;
	logic              done;
	logic [BYTE_W-1:0] control;
	logic [BYTE_W-1:0] sel;
	logic              sel_flag;
	logic              sel_esc;
	logic [BYTE_W-1:0] subst;
	logic [BYTE_W-1:0] byte_d;
	logic              fend_d;

	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              fend_q;

	assign load      = head_valid && (!valid_q || out_ready);
	assign phase_cur = (phase_q == PH_START) ?
	                   (head_job.first ? PH_HDR_FLAG : PH_PAY) : phase_q;
	assign control   = head_job.seq ? cfg.control_seq_one : cfg.control_seq_zero;
	assign sel       = (phase_cur == PH_CHK || phase_cur == PH_CHK_SUB) ?
	                   head_job.check : head_job.payload;
	assign sel_flag  = (sel == cfg.flag_code);
	assign sel_esc   = (sel == cfg.escape_code);
	assign subst     = sel_flag ? cfg.flag_substitute : cfg.escape_substitute;

	always_comb begin
		byte_d    = sel;
		fend_d    = 1'b0;
		done      = 1'b0;
		phase_nxt = PH_START;
		unique case (phase_cur)
			PH_HDR_FLAG: begin
				byte_d    = cfg.flag_code;
				phase_nxt = PH_HDR_ADDR;
			end
			PH_HDR_ADDR: begin
				byte_d    = cfg.address_code;
				phase_nxt = PH_HDR_CTRL;
			end
			PH_HDR_CTRL: begin
				byte_d    = control;
				phase_nxt = PH_HDR_CHK;
			end
			PH_HDR_CHK: begin
				byte_d    = cfg.address_code ^ control;
				phase_nxt = PH_PAY;
			end
			PH_PAY: begin
				if (sel_flag || sel_esc) begin
					byte_d    = cfg.escape_code;
					phase_nxt = PH_PAY_SUB;
				end else if (head_job.last) begin
					phase_nxt = PH_CHK;
				end else begin
					done = 1'b1;
				end
			end
			PH_PAY_SUB: begin
				byte_d = subst;
				if (head_job.last) begin
					phase_nxt = PH_CHK;
				end else begin
					done = 1'b1;
				end
			end
			PH_CHK: begin
				if (sel_flag || sel_esc) begin
					byte_d    = cfg.escape_code;
					phase_nxt = PH_CHK_SUB;
				end else begin
					phase_nxt = PH_CLOSE;
				end
			end
			PH_CHK_SUB: begin
				byte_d    = subst;
				phase_nxt = PH_CLOSE;
			end
			PH_CLOSE: begin
				byte_d = cfg.flag_code;
				fend_d = 1'b1;
				done   = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	assign pop = load && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= done ? PH_START : phase_nxt;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			last_q <= done;
			fend_q <= fend_d;
		end
	end

	assign out_valid = valid_q;
	assign line_byte = byte_q;
	assign run_last  = last_q;
	assign frame_end = fend_q;

	a_fend_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && fend_q) |-> last_q)
		else $error("closing flag not marked as last of run");
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_START) |-> head_valid)
		else $error("job left queue mid-expansion");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(byte_q) && $stable(last_q)))
		else $error("stalled output beat changed");

endmodule

// ----- test/testbench.sv -----
module testbench
	import ifsf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// register index that maps to no register; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// how long the line side refuses beats during the back-pressure phase
	localparam int unsigned RX_HOLD_CYCLES = 150;
	// cycles to let the back end settle after the last line beat
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned TAIL_CYCLES = 12;
	localparam int unsigned DRAIN_CAP = 50000;

	typedef struct {
		logic [7:0] line;
		logic       run_last;
		logic       frame_end;
	} line_beat_t;

	// Frame builder model plus the queue of line beats it still owes.
	class framer_scoreboard;
		cfg_t       regs;
		bit         in_frame;
		logic [7:0] check_xor;
		line_beat_t owed[$];
		int unsigned payload_beats;
		int unsigned line_beats;
		int unsigned frames;
		int unsigned failures;

		function new();
			regs.flag_code = RST_FLAG;
			regs.address_code = RST_ADDRESS;
			regs.escape_code = RST_ESCAPE;
			regs.flag_substitute = RST_FLAG_SUB;
			regs.escape_substitute = RST_ESC_SUB;
			regs.control_seq_zero = RST_CTRL_SEQ0;
			regs.control_seq_one = RST_CTRL_SEQ1;
			in_frame = 1'b0;
			check_xor = 8'h00;
			payload_beats = 0;
			line_beats = 0;
			frames = 0;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			case (idx)
				REG_FLAG:      regs.flag_code = val;
				REG_ADDRESS:   regs.address_code = val;
				REG_ESCAPE:    regs.escape_code = val;
				REG_FLAG_SUB:  regs.flag_substitute = val;
				REG_ESC_SUB:   regs.escape_substitute = val;
				REG_CTRL_SEQ0: regs.control_seq_zero = val;
				REG_CTRL_SEQ1: regs.control_seq_one = val;
				default: ;
			endcase
		endfunction

		function void owe(logic [7:0] b, logic fend);
			owed.push_back('{line: b, run_last: 1'b0, frame_end: fend});
		endfunction

		// flag wins over escape when both codes are equal
		function void owe_stuffed(logic [7:0] b);
			if (b == regs.flag_code) begin
				owe(regs.escape_code, 1'b0);
				owe(regs.flag_substitute, 1'b0);
			end else if (b == regs.escape_code) begin
				owe(regs.escape_code, 1'b0);
				owe(regs.escape_substitute, 1'b0);
			end else begin
				owe(b, 1'b0);
			end
		endfunction

		// Expand one accepted payload beat into the line beats it causes.
		function void note_payload(logic [7:0] pb, logic lb, logic sq);
			logic [7:0] ctrl;
			if (!in_frame) begin
				ctrl = sq ? regs.control_seq_one : regs.control_seq_zero;
				// header goes out raw, never stuffed
				owe(regs.flag_code, 1'b0);
				owe(regs.address_code, 1'b0);
				owe(ctrl, 1'b0);
				owe(regs.address_code ^ ctrl, 1'b0);
				check_xor = 8'h00;
				in_frame = 1'b1;
			end
			owe_stuffed(pb);
			check_xor = check_xor ^ pb;
			if (lb) begin
				owe_stuffed(check_xor);
				owe(regs.flag_code, 1'b1);
				in_frame = 1'b0;
				check_xor = 8'h00;
				frames++;
			end
			owed[owed.size() - 1].run_last = 1'b1;
			payload_beats++;
		endfunction

		function void check_line_beat(logic [7:0] d, logic l, logic u);
			line_beat_t want;
			line_beats++;
			if (owed.size() == 0) begin
				failures++;
				$display("%0t: unexpected line beat: expected none,", $time,
					" got byte %02h last %b end %b", d, l, u);
				return;
			end
			want = owed.pop_front();
			if (d !== want.line || l !== want.run_last || u !== want.frame_end) begin
				failures++;
				$display("%0t: line beat mismatch:", $time,
					" expected byte %02h last %b end %b,",
					want.line, want.run_last, want.frame_end,
					" got byte %02h last %b end %b", d, l, u);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;    // [7:0] payload_byte
	logic                 s_tlast;    // last_byte
	logic                 s_tuser;    // seq_bit
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;    // [7:0] line_byte
	logic                 m_tlast;    // run_last
	logic                 m_tuser;    // frame_end

	framer_scoreboard sb;

	// idle controls shared between the stimulus and the line-side process
	bit tx_quiet;
	bit rx_quiet;
	bit rx_hold;
	int unsigned settings;

	info_frame_stuffing_framer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Bias payload toward the codes that get stuffed under the current setup.
	function automatic logic [7:0] pick_payload();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return sb.regs.flag_code;
		if (r < 35)
			return sb.regs.escape_code;
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one payload beat, hold it until accepted, then log it for prediction.
	task automatic send_payload(input logic [7:0] pb, input logic lb, input logic sq);
		int unsigned gap;
		gap = pick_gap(tx_quiet);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = pb;
		s_tlast = lb;
		s_tuser = sq;
		do @(posedge clk); while (!s_tready);
		sb.note_payload(pb, lb, sq);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed line beat has come out.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (sb.owed.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic load_config(input logic [7:0] flag, input logic [7:0] addr,
			input logic [7:0] esc, input logic [7:0] flag_sub, input logic [7:0] esc_sub,
			input logic [7:0] ctrl0, input logic [7:0] ctrl1);
		wait_drained();
		write_reg(REG_FLAG, flag);
		write_reg(REG_ADDRESS, addr);
		write_reg(REG_ESCAPE, esc);
		write_reg(REG_FLAG_SUB, flag_sub);
		write_reg(REG_ESC_SUB, esc_sub);
		write_reg(REG_CTRL_SEQ0, ctrl0);
		write_reg(REG_CTRL_SEQ1, ctrl1);
		settings++;
	endtask

	// Whole frames of random length; seq is random on every beat to show
	// that only the opening beat of a frame picks the control byte.
	task automatic random_frames(input int unsigned count);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(7, 20);
			else
				len = $urandom_range(1, 5);
			for (int unsigned i = 0; i < len; i++) begin
				send_payload(pick_payload(), i == len - 1, 1'($urandom_range(0, 1)));
				sent++;
			end
		end
	endtask

	// Line side: accept with random stalls; on request, refuse for a long
	// stretch so the job queue fills and the payload side stalls too.
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				rx_hold = 1'b0;
				stall = RX_HOLD_CYCLES;
			end else begin
				stall = pick_gap(rx_quiet);
			end
			m_tready = (stall == 0);
			if (stall > 1)
				repeat (stall - 1) @(negedge clk);
		end
	end

	// Sample line beats at the rising edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_line_beat(m_tdata, m_tlast, m_tuser);
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned waited;
		sb = new();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold = 1'b0;
		settings = 1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset setup: one-beat frame whose only byte is the flag
		send_payload(8'h7e, 1'b1, 1'b0);
		// byte extremes, escape and flag in the body, seq flips mid-frame
		send_payload(8'h00, 1'b0, 1'b1);
		send_payload(8'hff, 1'b0, 1'b0);
		send_payload(8'h7d, 1'b0, 1'b0);
		send_payload(8'h7e, 1'b0, 1'b1);
		send_payload(8'h55, 1'b1, 1'b0);
		// check byte equal to escape, then equal to flag, then zero
		send_payload(8'h7d, 1'b1, 1'b1);
		send_payload(8'h01, 1'b0, 1'b0);
		send_payload(8'h7f, 1'b1, 1'b0);
		send_payload(8'haa, 1'b0, 1'b1);
		send_payload(8'haa, 1'b1, 1'b1);

		// Flag and escape share one code; header bytes collide with it too
		load_config(8'h55, 8'h55, 8'h55, 8'h11, 8'h22, 8'h55, 8'h00);
		write_reg(REG_UNUSED, 8'hff);
		send_payload(8'h55, 1'b1, 1'b0);
		send_payload(8'h00, 1'b0, 1'b1);
		send_payload(8'h55, 1'b0, 1'b0);
		send_payload(8'h12, 1'b1, 1'b0);

		// Extremes: every register all zeros, then all ones
		load_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		random_frames(40);
		load_config(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
		random_frames(40);

		// Random setup, both sides streaming with no idle cycles
		load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		random_frames(50);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// Header bytes and substitutes equal to the codes themselves
		load_config(8'h7e, 8'h7e, 8'h7d, 8'h7d, 8'h7e, 8'h7d, 8'h7e);
		random_frames(45);

		// Back to reset values; line side holds off while payload keeps coming
		load_config(RST_FLAG, RST_ADDRESS, RST_ESCAPE, RST_FLAG_SUB, RST_ESC_SUB,
			RST_CTRL_SEQ0, RST_CTRL_SEQ1);
		tx_quiet = 1'b1;
		rx_hold = 1'b1;
		random_frames(30);
		tx_quiet = 1'b0;
		// pause the payload side until the line side has caught up
		wait_drained();
		random_frames(50);

		// Drain, then give stray beats a chance to show up.
		s_tvalid = 1'b0;
		waited = 0;
		while (sb.owed.size() != 0 && waited < DRAIN_CAP) begin
			@(negedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.owed.size() != 0) begin
			sb.failures += sb.owed.size();
			$display("%0t: %0d line beats expected but never arrived, next byte %02h",
				$time, sb.owed.size(), sb.owed[0].line);
		end

		$display("Ran %0d payload beats in %0d frames, %0d line beats checked,",
			sb.payload_beats, sb.frames, sb.line_beats);
		$display("over %0d register setups with random stalls and a long line hold-off.",
			settings);
		if (sb.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
